// ===== sv/ngram_hash_row_index_defines.svh =====
// ----------------------------------------------------------------------------
// ngram hash row index assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NGRAM_HASH_ROW_INDEX_DEFINES_SVH
`define NGRAM_HASH_ROW_INDEX_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NGH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ngh assertion failed");
// next-cycle implication
`define NGH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ngh assertion failed");
`else
`define NGH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define NGH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/ngh_pkg.sv =====
// ----------------------------------------------------------------------------
// ngh_pkg
// Widths, codes and state type of the n-gram hash row index block.
// ----------------------------------------------------------------------------
package ngh_pkg;

	// parameter defaults
	localparam int MAX_NGRAM_DEF = 4;
	localparam int MAX_HPO_DEF   = 8;

	// field widths
	localparam int CMD_W      = 2;
	localparam int TOKEN_W    = 31;
	localparam int SLOT_W     = 5;
	localparam int VALUE_W    = 64;
	localparam int ROW_W      = 32;
	localparam int HEAD_NUM_W = 5;
	localparam int NGS_W      = 3;
	localparam int HPOR_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// item commands
	localparam logic [CMD_W-1:0] CMD_TOKEN    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_MULT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WR_MOD   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_WR_OFF   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NGRAM_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EOS_TOKEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HPO        = 2'd2;

	// remainder unit: 64-bit dividend, two quotient bits per cycle
	localparam int DIV_BITS  = 2;
	localparam int DIV_STEPS = VALUE_W / DIV_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_RD,
		ST_DIV,
		ST_EMIT
	} ngh_state_t;

endpackage

// ===== sv/ngh_if.sv =====
// ----------------------------------------------------------------------------
// ngh channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ngh_item_if import ngh_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [TOKEN_W-1:0] token;
	logic [SLOT_W-1:0]  slot;
	logic [VALUE_W-1:0] value;

	modport source (output valid, cmd, token, slot, value, input ready);
	modport sink   (input valid, cmd, token, slot, value, output ready);
endinterface

interface ngh_result_if import ngh_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ROW_W-1:0]      row_index;
	logic [HEAD_NUM_W-1:0] head_number;
	logic                  zero_modulus;
	logic                  last;

	modport source (output valid, row_index, head_number, zero_modulus, last, input ready);
	modport sink   (input valid, row_index, head_number, zero_modulus, last, output ready);
endinterface

interface ngh_cfg_if import ngh_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ngram_hash_row_index.sv =====
// ----------------------------------------------------------------------------
// ngram_hash_row_index
// Hashed n-gram embedding row index generator with table load items.
// ----------------------------------------------------------------------------
// channel  role    payload
// item     sink    cmd, token, slot, value
// result   source  row_index, head_number, zero_modulus, last
// cfg      sink    index, data (always ready)
//
// A table write item is written when it is transferred. A token item computes the
// products of each order (one shared 31x32 multiplier, low and high half of each
// multiplier word) before that order's heads; each head takes a memory read, the
// radix-4 remainder unit (ended early when the modulus is zero) and the result load.
// The history shifts when the token item is transferred; no item is taken until
// the last head is loaded. A stalled result holds only the head in flight.
// Reset sets the control registers and clears the table valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "ngram_hash_row_index_defines.svh"

module ngram_hash_row_index import ngh_pkg::*; #(
	parameter int MAX_NGRAM           = MAX_NGRAM_DEF,
	parameter int MAX_HEADS_PER_ORDER = MAX_HPO_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ngh_item_if.sink     item,
	ngh_result_if.source result,
	ngh_cfg_if.sink      cfg
);

	localparam int HIST_D     = MAX_NGRAM - 1;
	localparam int HEAD_COUNT = (MAX_NGRAM - 1) * MAX_HEADS_PER_ORDER;
	localparam int HEAD_W     = (HEAD_COUNT > 1) ? $clog2(HEAD_COUNT) : 1;
	localparam int MULT_W     = $clog2(MAX_NGRAM);
	localparam int NG_W       = $clog2(MAX_NGRAM + 1);
	localparam int HPO_W      = $clog2(MAX_HEADS_PER_ORDER + 1);
	localparam int CNT_W      = $clog2(DIV_STEPS);

	ngh_state_t state_q, state_d;

	// configuration
	logic [NGS_W-1:0]   ngram_size_q;
	logic [TOKEN_W-1:0] eos_q;
	logic [HPOR_W-1:0]  hpo_cfg_q;

	// history and tables
	logic [TOKEN_W-1:0] hist_tok_q [HIST_D];
	logic [HIST_D-1:0]  hist_emp_q;
	logic [VALUE_W-1:0] mult_q [MAX_NGRAM];
	logic [ROW_W-1:0]   mod_mem [HEAD_COUNT];
	logic [ROW_W-1:0]   off_mem [HEAD_COUNT];
	logic [HEAD_COUNT-1:0] mod_vld_q, off_vld_q;
	logic [ROW_W-1:0]   mod_rd_q, off_rd_q;
	logic               mod_rd_vld_q, off_rd_vld_q;

	// per-token work
	logic [TOKEN_W-1:0] ctx_q [MAX_NGRAM];
	logic [TOKEN_W-1:0] ctx_d [MAX_NGRAM];
	logic [NG_W-1:0]    n_q, n_d;
	logic [HPO_W-1:0]   hpo_q, hpo_d;
	logic [MULT_W-1:0]  j_q;
	logic [HPO_W-1:0]   g_q;
	logic [HEAD_W-1:0]  h_q;
	logic [ROW_W-1:0]   mul_b;
	logic [62:0]        prod;
	logic [62:0]        prod_lo_q;
	logic [ROW_W-1:0]   prod_hi_q;
	logic [VALUE_W-1:0] acc_q, term;
	logic [VALUE_W-1:0] dvd_q, dvd_d;
	logic [ROW_W-1:0]   rem_q, rem_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [ROW_W-1:0]   mod_val, off_val;

	// result register
	logic                  out_vld_q;
	logic [ROW_W-1:0]      out_row_q;
	logic [HEAD_NUM_W-1:0] out_head_q;
	logic                  out_zero_q;
	logic                  out_last_q;

	// control
	logic item_xfer, tok_xfer, cfg_xfer;
	logic has_work, out_free, load_out;
	logic last_head, last_order, mod_zero;
	logic wr_mult, wr_mod, wr_off;

	assign item_xfer = item.valid && item.ready;
	assign tok_xfer  = item_xfer && (item.cmd == CMD_TOKEN);
	assign cfg_xfer  = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	assign wr_mult = item_xfer && (item.cmd == CMD_WR_MULT) && (int'(item.slot) < MAX_NGRAM);
	assign wr_mod  = item_xfer && (item.cmd == CMD_WR_MOD) && (int'(item.slot) < HEAD_COUNT);
	assign wr_off  = item_xfer && (item.cmd == CMD_WR_OFF) && (int'(item.slot) < HEAD_COUNT);

	// saturate configuration to the built sizes
	assign n_d   = (int'(ngram_size_q) > MAX_NGRAM) ? NG_W'(MAX_NGRAM) : NG_W'(ngram_size_q);
	assign hpo_d = (int'(hpo_cfg_q) > MAX_HEADS_PER_ORDER) ? HPO_W'(MAX_HEADS_PER_ORDER)
	                                                      : HPO_W'(hpo_cfg_q);
	assign has_work = (n_d >= NG_W'(2)) && (hpo_d != '0);

	// context: cut at the first empty or eos history entry
	always_comb begin
		logic cut;
		cut = 1'b0;
		ctx_d[0] = item.token;
		for (int s = 1; s < MAX_NGRAM; s++) begin
			cut = cut || hist_emp_q[s-1] || (hist_tok_q[s-1] == eos_q);
			ctx_d[s] = cut ? eos_q : hist_tok_q[s-1];
		end
	end

	// shared multiplier, low then high half of the multiplier word
	assign mul_b = (state_q == ST_MUL_LO) ? mult_q[j_q][31:0] : mult_q[j_q][63:32];
	assign prod  = 63'(ctx_q[j_q]) * 63'(mul_b);
	assign term  = VALUE_W'(prod_lo_q) + {prod_hi_q, 32'h0};

	assign mod_val  = mod_rd_vld_q ? mod_rd_q : '0;
	assign off_val  = off_rd_vld_q ? off_rd_q : '0;
	assign mod_zero = (mod_val == '0);

	assign last_head  = (g_q + HPO_W'(1)) == hpo_q;
	assign last_order = (NG_W'(j_q) + NG_W'(1)) == n_q;
	assign out_free   = !out_vld_q || result.ready;

	// restoring remainder, DIV_BITS dividend bits per cycle
	always_comb begin
		logic [ROW_W:0]     r;
		logic [VALUE_W-1:0] dv;
		r  = {1'b0, rem_q};
		dv = dvd_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			r  = {r[ROW_W-1:0], dv[VALUE_W-1]};
			dv = {dv[VALUE_W-2:0], 1'b0};
			if (r >= {1'b0, mod_val}) begin
				r = r - {1'b0, mod_val};
			end
		end
		rem_d = r[ROW_W-1:0];
		dvd_d = dv;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tok_xfer && has_work) state_d = ST_MUL_LO;
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_ACC;
			ST_ACC: begin
				state_d = (j_q == '0) ? ST_MUL_LO : ST_RD;
			end
			ST_RD: state_d = ST_DIV;
			ST_DIV: begin
				if (mod_zero || cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					if (!last_head) state_d = ST_RD;
					else if (!last_order) state_d = ST_MUL_LO;
					else state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item.ready = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_EMIT: load_out = out_free;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ngram_size_q <= NGS_W'(2);
			eos_q        <= '0;
			hpo_cfg_q    <= HPOR_W'(1);
			hist_emp_q   <= '1;
			mod_vld_q    <= '0;
			off_vld_q    <= '0;
			for (int i = 0; i < MAX_NGRAM; i++) begin
				mult_q[i] <= '0;
			end
			n_q          <= '0;
			hpo_q        <= '0;
			j_q          <= '0;
			g_q          <= '0;
			h_q          <= '0;
			cnt_q        <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_xfer) begin
				unique case (cfg.index)
					REG_NGRAM_SIZE: ngram_size_q <= cfg.data[NGS_W-1:0];
					REG_EOS_TOKEN:  eos_q        <= cfg.data[TOKEN_W-1:0];
					REG_HPO:        hpo_cfg_q    <= cfg.data[HPOR_W-1:0];
					default: ;
				endcase
			end
			if (wr_mult) mult_q[MULT_W'(item.slot)] <= item.value;
			if (wr_mod) mod_vld_q[HEAD_W'(item.slot)] <= 1'b1;
			if (wr_off) off_vld_q[HEAD_W'(item.slot)] <= 1'b1;
			if (tok_xfer) begin
				for (int s = HIST_D - 1; s > 0; s--) begin
					hist_emp_q[s] <= hist_emp_q[s-1];
				end
				hist_emp_q[0] <= 1'b0;
				n_q   <= n_d;
				hpo_q <= hpo_d;
				j_q   <= '0;
				g_q   <= '0;
				h_q   <= '0;
			end
			if (state_q == ST_ACC) begin
				if (j_q == '0) j_q <= MULT_W'(1);
				g_q <= '0;
			end
			if (state_q == ST_RD) cnt_q <= '0;
			if (state_q == ST_DIV) cnt_q <= cnt_q + CNT_W'(1);
			if (load_out) begin
				h_q <= h_q + HEAD_W'(1);
				if (!last_head) g_q <= g_q + HPO_W'(1);
				else if (!last_order) j_q <= j_q + MULT_W'(1);
			end
			if (load_out) out_vld_q <= 1'b1;
			else if (result.ready) out_vld_q <= 1'b0;
		end
	end

	// table memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (wr_mod) mod_mem[HEAD_W'(item.slot)] <= item.value[ROW_W-1:0];
		if (wr_off) off_mem[HEAD_W'(item.slot)] <= item.value[ROW_W-1:0];
		mod_rd_q     <= mod_mem[h_q];
		off_rd_q     <= off_mem[h_q];
		mod_rd_vld_q <= mod_vld_q[h_q];
		off_rd_vld_q <= off_vld_q[h_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (tok_xfer) begin
			for (int s = HIST_D - 1; s > 0; s--) begin
				hist_tok_q[s] <= hist_tok_q[s-1];
			end
			hist_tok_q[0] <= item.token;
			for (int s = 0; s < MAX_NGRAM; s++) begin
				ctx_q[s] <= ctx_d[s];
			end
			acc_q <= '0;
		end
		if (state_q == ST_MUL_LO) prod_lo_q <= prod;
		if (state_q == ST_MUL_HI) prod_hi_q <= prod[ROW_W-1:0];
		if (state_q == ST_ACC) acc_q <= acc_q ^ term;
		if (state_q == ST_RD) begin
			rem_q <= '0;
			dvd_q <= acc_q;
		end
		if (state_q == ST_DIV && !mod_zero) begin
			rem_q <= rem_d;
			dvd_q <= dvd_d;
		end
		if (load_out) begin
			out_row_q  <= rem_q + off_val;
			out_head_q <= HEAD_NUM_W'(h_q);
			out_zero_q <= mod_zero;
			out_last_q <= last_head && last_order;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.row_index    = out_row_q;
	assign result.head_number  = out_head_q;
	assign result.zero_modulus = out_zero_q;
	assign result.last         = out_last_q;

	// partial remainder stays below the divisor
	`NGH_ASSERT_IMPLIES(a_rem_below_mod, clk, arst_n, (state_q == ST_DIV) && !mod_zero, rem_q < mod_val)
	// head and order counters stay inside the current token's shape
	`NGH_ASSERT_IMPLIES(a_g_range, clk, arst_n, state_q != ST_IDLE, g_q < hpo_q)
	`NGH_ASSERT_IMPLIES(a_j_range, clk, arst_n, state_q != ST_IDLE, NG_W'(j_q) < n_q)
	`NGH_ASSERT_IMPLIES(a_head_bound, clk, arst_n, load_out, int'(h_q) < (int'(n_q) - 1) * int'(hpo_q))
	// table writes never start hashing work
	`NGH_ASSERT_NEXT(a_wr_stays_idle, clk, arst_n, item_xfer && (item.cmd != CMD_TOKEN), state_q == ST_IDLE)

endmodule
